### rtl/htd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package htd_pkg;
  localparam int NodeCount = 512;
  localparam int NodeW = 9;
  localparam int MaxCodeLen = 32;
  localparam int MaxSymW = 16;

  localparam logic [1:0] OpClear = 2'd0;
  localparam logic [1:0] OpLoad = 2'd1;
  localparam logic [1:0] OpStart = 2'd2;
  localparam logic [1:0] OpDecode = 2'd3;

  localparam logic [1:0] KindData = 2'd0;
  localparam logic [1:0] KindDone = 2'd1;
  localparam logic [1:0] KindError = 2'd2;
  localparam logic [1:0] KindFull = 2'd3;

  localparam logic RegSymW = 1'b0;
  localparam logic RegFileBytes = 1'b1;
endpackage
`default_nettype wire

### rtl/huffman_tree_decoder_top.sv
// Clear empties the tree and start resets the walk; a load walks the tree along its code bits,
// allocating missing nodes; a decode byte walks it on the compressed bits and emits the symbol
// bits of each leaf it reaches. One item at a time; busy is high while an item is in work.
// The node table memory is read once per tree step (registered read) and sets the step rate.
// Reset clears control state; the root reads as empty until written, later nodes are written
// when allocated. The receiver cannot stall, every result is shown for one cycle.
`timescale 1ns / 1ps
`default_nettype none
module huffman_tree_decoder_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  operation_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [31:0] code_bits_i,
  input  wire logic [5:0]  code_length_i,
  input  wire logic [15:0] symbol_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output logic             result_valid_o,
  output logic [7:0]       out_byte_o,
  output logic [1:0]       kind_o,
  output logic             last_o
);
  import htd_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StLStep = 3'd2;
  localparam logic [2:0] StDStep = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  logic [2:0] state_q, state_d;
  logic [4:0] symw_q;
  logic [31:0] fbytes_q;
  logic [1:0] op_q;
  logic [7:0] data_q;
  logic [31:0] code_q;
  logic [5:0] cnt_q, cnt_d;      // remaining bits of the item
  logic [15:0] sym_q;
  logic [NodeW-1:0] cur_q, cur_d;
  logic [NodeW:0] used_q, used_d;
  logic [NodeW-1:0] walk_q, walk_d;
  logic [7:0] pbits_q, pbits_d;
  logic [2:0] pcnt_q, pcnt_d;
  logic [34:0] emitted_q, emitted_d;
  logic [15:0] esym_q, esym_d;
  logic [4:0] epos_q, epos_d;    // symbol bits left to emit
  logic full_q, full_d;

  // node table: {left, right, symbol}; the root reads as empty until written
  // after reset or clear, every other node is written when allocated
  logic [2*NodeW+15:0] mem [NodeCount];
  logic root_set_q;
  logic [NodeW-1:0] raddr;
  logic [2*NodeW+15:0] rd_q, rd;
  logic rvld_q;
  logic we;
  logic [NodeW-1:0] waddr;
  logic [2*NodeW+15:0] wdata;
  logic we2;
  logic [NodeW-1:0] waddr2;
  logic clr_all;

  logic [NodeW-1:0] lc, rc;
  assign rd = rvld_q ? rd_q : '0;
  assign lc = rd[2*NodeW+15:NodeW+16];
  assign rc = rd[NodeW+15:16];

  logic [34:0] total;
  assign total = {fbytes_q, 3'b000};
  logic [4:0] wclip;
  always_comb begin
    wclip = symw_q;
    if (wclip == 5'd0) wclip = 5'd1;
    if (wclip > 5'(MaxSymW)) wclip = 5'(MaxSymW);
  end

  logic bit_l, bit_d;
  logic [NodeW-1:0] ch_l, ch_d;
  assign bit_l = code_q[cnt_q[4:0] - 5'd1] ;
  assign bit_d = data_q[cnt_q[2:0] - 3'd1];
  assign ch_l = bit_l ? rc : lc;
  assign ch_d = bit_d ? rc : lc;

  logic res_v;
  logic [7:0] res_b;
  logic [1:0] res_k;
  logic res_l;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; cur_d = cur_q; used_d = used_q; walk_d = walk_q;
    pbits_d = pbits_q; pcnt_d = pcnt_q; emitted_d = emitted_q; esym_d = esym_q;
    epos_d = epos_q; full_d = full_q;
    raddr = cur_q; we = 1'b0; waddr = cur_q; wdata = '0; we2 = 1'b0; waddr2 = cur_q;
    clr_all = 1'b0;
    res_v = 1'b0; res_b = '0; res_k = KindDone; res_l = 1'b0;
    case (state_q)
      StIdle: begin
        if (start) begin
          full_d = 1'b0;
          case (operation_i)
            OpClear: begin
              used_d = (NodeW+1)'(1); walk_d = '0; clr_all = 1'b1; state_d = StDone;
            end
            OpLoad: begin
              cnt_d = (code_length_i > 6'(MaxCodeLen)) ? 6'(MaxCodeLen) : code_length_i;
              cur_d = '0; raddr = '0;
              state_d = (cnt_d == 6'd0) ? StDone : StLStep;
            end
            OpStart: begin
              walk_d = '0; pbits_d = '0; pcnt_d = '0; emitted_d = '0; state_d = StDone;
            end
            default: begin
              cnt_d = 6'd8; cur_d = walk_q; raddr = walk_q; state_d = StDStep;
            end
          endcase
        end
      end
      StRead: begin
        raddr = cur_q;
        state_d = (op_q == OpLoad) ? StLStep : StDStep;
      end
      StLStep: begin
        // rd holds node cur_q
        if (ch_l == '0) begin
          if (used_q >= (NodeW+1)'(NodeCount)) begin
            full_d = 1'b1; state_d = StDone;
          end else begin
            used_d = used_q + 1'b1;
            we = 1'b1; waddr = cur_q;
            wdata = bit_l ? {lc, used_q[NodeW-1:0], rd[15:0]}
                          : {used_q[NodeW-1:0], rc, rd[15:0]};
            we2 = 1'b1; waddr2 = used_q[NodeW-1:0];
            cur_d = used_q[NodeW-1:0];
            cnt_d = cnt_q - 6'd1;
            state_d = (cnt_q == 6'd1) ? StDone : StRead;
          end
        end else begin
          cur_d = ch_l; cnt_d = cnt_q - 6'd1;
          if (cnt_q == 6'd1) begin
            we2 = 1'b1; waddr2 = ch_l; state_d = StDone;
          end else state_d = StRead;
        end
      end
      StDStep: begin
        if (cnt_q == 6'd0 || emitted_q >= total) begin
          state_d = StDone;
        end else if (ch_d == '0) begin
          res_v = 1'b1; res_k = KindError;
          walk_d = '0; cur_d = '0; cnt_d = cnt_q - 6'd1; state_d = StRead;
        end else begin
          // fetch the child for the leaf test
          walk_d = ch_d; cur_d = ch_d; cnt_d = cnt_q - 6'd1; raddr = ch_d;
          state_d = StEmit;
        end
      end
      StEmit: begin
        // rd holds child node; emit if leaf
        if (epos_q == 5'd0) begin
          if (lc == '0 && rc == '0) begin
            esym_d = rd[15:0]; epos_d = wclip; walk_d = '0; cur_d = '0;
          end else begin
            raddr = cur_q; state_d = StDStep;
          end
        end else if (emitted_q >= total) begin
          epos_d = '0; raddr = cur_q; state_d = StDStep;
        end else begin
          pbits_d = {pbits_q[6:0], esym_q[4'(epos_q - 5'd1)]};
          pcnt_d = pcnt_q + 3'd1;
          emitted_d = emitted_q + 35'd1;
          epos_d = epos_q - 5'd1;
          if (pcnt_q == 3'd7) begin
            res_v = 1'b1; res_k = KindData; res_b = pbits_d;
          end
          if (epos_q == 5'd1) begin raddr = cur_q; state_d = StDStep; end
        end
      end
      StDone: begin
        res_v = 1'b1; res_l = 1'b1; res_k = full_q ? KindFull : KindDone;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (we2) mem[waddr2] <= {{(2*NodeW){1'b0}}, sym_q};
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_set_q <= 1'b0; rvld_q <= 1'b0;
    end else begin
      rvld_q <= (raddr != '0) || root_set_q;
      if (clr_all) root_set_q <= 1'b0;
      else if (we && waddr == '0) root_set_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      op_q <= operation_i; data_q <= data_byte_i; code_q <= code_bits_i; sym_q <= symbol_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; symw_q <= 5'd8; fbytes_q <= '0; cnt_q <= '0; cur_q <= '0;
      used_q <= (NodeW+1)'(1); walk_q <= '0; pbits_q <= '0; pcnt_q <= '0;
      emitted_q <= '0; esym_q <= '0; epos_q <= '0; full_q <= 1'b0;
      result_valid_o <= 1'b0; out_byte_o <= '0; kind_o <= '0; last_o <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; cur_q <= cur_d; used_q <= used_d;
      walk_q <= walk_d; pbits_q <= (res_v && res_k == KindData) ? 8'd0 : pbits_d;
      pcnt_q <= pcnt_d; emitted_q <= emitted_d; esym_q <= esym_d; epos_q <= epos_d;
      full_q <= full_d;
      result_valid_o <= res_v; out_byte_o <= res_b; kind_o <= res_k; last_o <= res_l;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegSymW: symw_q <= cfg_data_i[4:0];
          RegFileBytes: fbytes_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign busy = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= (NodeW+1)'(NodeCount)) else $error("node count overflow");
  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("item not taken");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |-> !busy) else $error("last before idle");
endmodule
`default_nettype wire
